>>> rtl/spnt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the note boundary table for the spectrum peak
// note tracker. No dependencies.
package spnt_pkg;

  localparam int FFT_SIZE  = 4096;
  localparam int HALF_BINS = FFT_SIZE / 2;
  localparam int LOG2_FFT  = $clog2(FFT_SIZE);
  localparam int CNT_W     = $clog2(HALF_BINS + 1);
  localparam int IDX_W     = $clog2(HALF_BINS);

  localparam int MAG_W  = 32;
  localparam int THR_W  = 25;
  localparam int SR_W   = 18;
  localparam int SF_W   = 8;
  localparam int CFG_W  = 25;
  localparam int NOTE_W = 7;
  localparam int FQ_W   = 25;

  localparam int DEN_MIN  = 1678;
  localparam int DEN_W    = MAG_W + 3;
  localparam int DVS_W    = MAG_W + 2;
  localparam int DVD_W    = MAG_W + 16;
  localparam int SD_W     = DVD_W + 2;
  localparam int REF_W    = 39;
  localparam int LO_W     = 20;
  localparam int PROD_W   = REF_W + SR_W;
  localparam int FQ_SHIFT = LOG2_FFT + 8;
  localparam int RUN_MAX  = 255;

  localparam int NOTE_FIRST = 23;
  localparam int NB         = 74;
  localparam int NB_W       = $clog2(NB);
  localparam int BND_W      = 20;

  typedef enum logic [1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_SAMPLE_RATE = 2'd1,
    CFG_STABLE      = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ_RE, F_SQ_IM, F_SUM, F_SQRT, F_TRACK, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_REF, B_MUL_LO, B_MUL_HI, B_SUM, B_NOTE, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [MAG_W-1:0] peak;
    logic [MAG_W-1:0] left;
    logic [MAG_W-1:0] right;
    logic [IDX_W-1:0] index;
    logic             interior;
  } job_t;

  typedef logic [BND_W-1:0] bnd_arr_t [NB];

  // Q.8 upper boundary of notes 23..96, from the top octave in Q.16 rounded up
  function automatic bnd_arr_t make_bounds();
    bnd_arr_t b;
    logic [31:0] top [12];
    int o;
    int k;
    longint unsigned t;
    top = '{32'd74790916, 32'd79238215, 32'd83949965, 32'd88941889,
            32'd94230649, 32'd99833895, 32'd105770327, 32'd112059758,
            32'd118723178, 32'd125782826, 32'd133262262, 32'd141186449};
    for (int n = 0; n < NB; n++) begin
      o = n + NOTE_FIRST - 85;
      k = 0;
      while (o < 0) begin
        o = o + 12;
        k = k + 1;
      end
      t = (64'(top[o]) + (64'd1 << (8 + k)) - 64'd1) >> (8 + k);
      b[n] = t[BND_W-1:0];
    end
    return b;
  endfunction

  localparam bnd_arr_t BOUNDS = make_bounds();

endpackage

>>> rtl/spnt_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between front and back ends.
// Depends on spnt_pkg.
module spnt_queue import spnt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/spnt_front.sv
`timescale 1ns / 1ps
// Front end: accepts bins, computes magnitude with a bit-serial square root,
// tracks the frame peak and queues a request at the frame end. Uses spnt_pkg.
module spnt_front import spnt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  output job_t        job,
  output logic        job_valid,
  input  logic        job_ready
);

  front_state_t     state_r, state_nxt;
  logic [31:0]      re_r, im_r;
  logic             last_r;
  logic [63:0]      sq_r, s_r, s_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] prev_r, prev_nxt, best_r, best_nxt;
  logic [MAG_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt, lseen_r, lseen_nxt;
  logic [MAG_W-1:0] mag;
  logic [63:0]      trial;
  logic             in_range;
  logic [31:0]      re_abs, im_abs;

  assign re_abs   = in_tdata[31] ? 32'(-in_tdata[31:0]) : in_tdata[31:0];
  assign im_abs   = in_tdata[63] ? 32'(-in_tdata[63:32]) : in_tdata[63:32];
  assign mag      = MAG_W'(r_r >> LOG2_FFT);
  assign trial    = r_r + bit_r;
  assign in_range = cnt_r < CNT_W'(HALF_BINS);

  assign in_tready = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign job.peak     = best_r;
  assign job.left     = left_r;
  assign job.right    = right_r;
  assign job.index    = bidx_r;
  assign job.interior = bidx_r < lseen_r;

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    r_nxt     = r_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    best_nxt  = best_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    bidx_nxt  = bidx_r;
    lseen_nxt = lseen_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) state_nxt = F_SQ_RE;
      end
      F_SQ_RE: state_nxt = F_SQ_IM;
      F_SQ_IM: begin
        s_nxt     = im_r * im_r;
        state_nxt = F_SUM;
      end
      F_SUM: begin
        s_nxt     = sq_r + s_r;
        r_nxt     = '0;
        bit_nxt   = 64'd1 << 62;
        step_nxt  = '0;
        state_nxt = F_SQRT;
      end
      F_SQRT: begin
        if (s_r >= trial) begin
          s_nxt = s_r - trial;
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) state_nxt = F_TRACK;
      end
      F_TRACK: begin
        if (in_range) begin
          if (cnt_r >= CNT_W'(3) && CNT_W'(bidx_r) == cnt_r - CNT_W'(1)) right_nxt = mag;
          if (cnt_r == CNT_W'(2) || (cnt_r > CNT_W'(2) && mag > best_r)) begin
            best_nxt = mag;
            bidx_nxt = cnt_r[IDX_W-1:0];
            left_nxt = prev_r;
          end
          prev_nxt = mag;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        lseen_nxt = in_range ? cnt_r[IDX_W-1:0] : IDX_W'(HALF_BINS - 1);
        state_nxt = last_r ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (job_ready) begin
          cnt_nxt   = '0;
          prev_nxt  = '0;
          best_nxt  = '0;
          left_nxt  = '0;
          right_nxt = '0;
          bidx_nxt  = IDX_W'(2);
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      re_r   <= re_abs;
      im_r   <= im_abs;
      last_r <= in_tlast;
    end
    if (state_r == F_SQ_RE) sq_r <= re_r * re_r;
    s_r     <= s_nxt;
    r_r     <= r_nxt;
    bit_r   <= bit_nxt;
    step_r  <= step_nxt;
    lseen_r <= lseen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
      prev_r  <= '0;
      best_r  <= '0;
      left_r  <= '0;
      right_r <= '0;
      bidx_r  <= IDX_W'(2);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      best_r  <= best_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

endmodule

>>> rtl/spnt_back.sv
`timescale 1ns / 1ps
// Back end: parabolic correction by serial division, hertz conversion,
// note search, stability tracking and the output register. Uses spnt_pkg.
module spnt_back import spnt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  job_t             job,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [THR_W-1:0] thr,
  input  logic [SR_W-1:0]  sample_rate,
  input  logic [SF_W-1:0]  stable_frames,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,
  output logic             out_tuser
);

  back_state_t        state_r, state_nxt;
  job_t               job_r;
  logic               neg_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   dvs_r, rem_r;
  logic [5:0]         step_r;
  logic [REF_W-1:0]   ref_r;
  logic [37:0]        plo_r;
  logic [36:0]        phi_r;
  logic [FQ_W-1:0]    fq_r;
  logic [NB_W-1:0]    j_r;
  logic [NOTE_W-1:0]  note_r;

  logic [NOTE_W-1:0]  held_r;
  logic [SF_W-1:0]    run_r;
  logic               have_r;

  logic               ov_r, nv_r;
  logic [NOTE_W-1:0]  onote_r;
  logic [FQ_W-1:0]    ofq_r;
  logic [MAG_W-1:0]   omag_r;

  logic signed [DEN_W-1:0] den;
  logic signed [MAG_W:0]   num;
  logic [DVS_W-1:0]        den_abs;
  logic [MAG_W:0]          num_abs;
  logic                    above, use_corr;
  logic [DVS_W:0]          rem_sh;
  logic signed [SD_W-1:0]  sd, refined;
  logic [PROD_W-1:0]       prod;
  logic                    less;
  logic                    out_free;
  logic [SF_W-1:0]         run_new;

  assign den = $signed({3'b0, job.left}) - $signed({2'b0, job.peak, 1'b0})
             + $signed({3'b0, job.right});
  assign num = $signed({1'b0, job.left}) - $signed({1'b0, job.right});
  assign den_abs  = den[DEN_W-1] ? DVS_W'(-den) : DVS_W'(den);
  assign num_abs  = num[MAG_W] ? (MAG_W+1)'(-num) : (MAG_W+1)'(num);
  assign above    = job.peak > MAG_W'(thr);
  assign use_corr = job.interior && den_abs >= DVS_W'(DEN_MIN);

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign sd      = neg_r ? -$signed({2'b0, dvd_r}) : $signed({2'b0, dvd_r});
  assign refined = $signed(SD_W'({job_r.index, 16'b0})) + sd;
  assign prod    = (PROD_W'(phi_r) << LO_W) + PROD_W'(plo_r);
  assign less    = fq_r < FQ_W'(BOUNDS[j_r]);
  assign out_free = !ov_r || out_tready;
  assign run_new  = (have_r && held_r == note_r)
                  ? ((run_r < SF_W'(RUN_MAX)) ? run_r + SF_W'(1) : run_r) : SF_W'(1);

  assign job_ready  = (state_r == B_IDLE);
  assign out_tvalid = ov_r;
  // note_number [6:0], frequency_q8 [31:7], peak_magnitude [63:32]
  assign out_tdata  = {omag_r, ofq_r, onote_r};
  assign out_tuser  = nv_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          if (!above) state_nxt = B_NOTE;
          else if (use_corr) state_nxt = B_DIV;
          else state_nxt = B_REF;
        end
      end
      B_DIV:    if (step_r == 6'(DVD_W - 1)) state_nxt = B_REF;
      B_REF:    state_nxt = B_MUL_LO;
      B_MUL_LO: state_nxt = B_MUL_HI;
      B_MUL_HI: state_nxt = B_SUM;
      B_SUM:    state_nxt = B_NOTE;
      B_NOTE:   if (less || j_r == NB_W'(NB - 1)) state_nxt = B_DONE;
      B_DONE:   if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r  <= job;
        neg_r  <= num[MAG_W] ^ den[DEN_W-1];
        dvd_r  <= use_corr ? {num_abs, 15'b0} : '0;
        dvs_r  <= den_abs;
        rem_r  <= '0;
        step_r <= '0;
        fq_r   <= '0;
        j_r    <= '0;
      end
      B_DIV: begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= DVS_W'(rem_sh - {1'b0, dvs_r});
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DVS_W-1:0];
          dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
      end
      B_REF: begin
        ref_r <= (!refined[SD_W-1] && refined != '0) ? refined[REF_W-1:0] : '0;
      end
      B_MUL_LO: plo_r <= ref_r[LO_W-1:0] * sample_rate;
      B_MUL_HI: phi_r <= ref_r[REF_W-1:LO_W] * sample_rate;
      B_SUM: begin
        fq_r <= (|prod[PROD_W-1:FQ_SHIFT+FQ_W]) ? '1 : prod[FQ_SHIFT+FQ_W-1:FQ_SHIFT];
      end
      B_NOTE: begin
        if (less) note_r <= (j_r == '0) ? '0 : NOTE_W'(j_r) + NOTE_W'(NOTE_FIRST);
        else if (j_r == NB_W'(NB - 1)) note_r <= '0;
        else j_r <= j_r + NB_W'(1);
      end
      B_DONE: begin
        if (out_free) begin
          onote_r <= (note_r != '0 && run_new >= stable_frames) ? note_r : '0;
          ofq_r   <= fq_r;
          omag_r  <= job_r.peak;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      held_r  <= '0;
      run_r   <= '0;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
      nv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DONE && out_free) begin
        ov_r <= 1'b1;
        if (note_r != '0) begin
          held_r <= note_r;
          run_r  <= run_new;
          have_r <= 1'b1;
          nv_r   <= run_new >= stable_frames;
        end else begin
          held_r <= '0;
          run_r  <= '0;
          have_r <= 1'b0;
          nv_r   <= 1'b0;
        end
      end else if (ov_r && out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/spectrum_peak_note_tracker.sv
`timescale 1ns / 1ps
// Spectrum peak note tracker: FFT bins in, one note report per frame out.
// Holds the configuration registers; uses spnt_pkg, spnt_front, spnt_queue,
// spnt_back.
//
// Input: one FFT bin per request, bin 0 first, in_tlast on the frame's last
// bin. Each bin passes through squaring and a one-bit-per-cycle square root
// of the magnitude before the next bin is accepted; the frame's last bin
// then waits in a push state to queue the request.
// Output: one note report per frame, after the serial divide (when the
// parabolic correction applies) and the serial note search. out_tuser is
// note_valid.
// A two-entry queue separates peak search from note mapping, so bins keep
// flowing while earlier frames finish or while the receiver stalls; the
// output register holds a result until taken and bins stall only once the
// queue is full.
// Reset (rst_n low, synchronous) clears frame and note history and loads the
// default configuration. Write configuration only while idle.
module spectrum_peak_note_tracker import spnt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // bin_real [31:0], bin_imag [63:32]
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata,  // note_number, frequency_q8, peak_magnitude
  output logic             out_tuser,  // note_valid
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [THR_W-1:0] thr_r;
  logic [SR_W-1:0]  sr_r;
  logic [SF_W-1:0]  sf_r;
  job_t             f_job, q_job;
  logic             f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(167772);
      sr_r  <= SR_W'(48000);
      sf_r  <= SF_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:   thr_r <= cfg_data[THR_W-1:0];
        CFG_SAMPLE_RATE: sr_r  <= cfg_data[SR_W-1:0];
        CFG_STABLE:      sf_r  <= cfg_data[SF_W-1:0];
        default: ;
      endcase
    end
  end

  spnt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  spnt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_job    (q_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  spnt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (q_job),
    .job_valid     (q_valid),
    .job_ready     (q_ready),
    .thr           (thr_r),
    .sample_rate   (sr_r),
    .stable_frames (sf_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule
